// ===== sv/dmx_pkg.sv =====
// Shared types and constants for the PCM channel downmix mixer.
// Holds the widths, the gain table geometry, the command codes and the sequencer states.
// Used by pcm_channel_downmix_mixer_core; depends on nothing else.
package dmx_pkg;

	// Field widths of the item, result and configuration ports.
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned CFG_W    = 4;
	localparam int unsigned CFG_IDX_W = 1;

	// The gain table is addressed as {output channel, input channel}.
	localparam int unsigned TBL_SIDE   = 8;
	localparam int unsigned TBL_ADDR_W = 2 * IDX_W;
	localparam int unsigned TBL_DEPTH  = TBL_SIDE * TBL_SIDE;

	// Default channel limits for the top-level parameters.
	localparam int unsigned MAX_IN_DEF  = 8;
	localparam int unsigned MAX_OUT_DEF = 8;

	// Reset values of the channel count registers.
	localparam logic [CFG_W-1:0] IN_CNT_RST  = 4'd2;
	localparam logic [CFG_W-1:0] OUT_CNT_RST = 4'd2;

	// Arithmetic: signed sample times unsigned Q4.12 gain, summed over up to eight terms.
	localparam int unsigned GAIN_FRAC = 12;
	localparam int unsigned PROD_W    = SAMPLE_W + GAIN_W + 1;
	localparam int unsigned ACC_W     = PROD_W + 3;
	localparam int unsigned RND_W     = ACC_W - GAIN_FRAC;
	localparam logic signed [ACC_W-1:0] GAIN_HALF = ACC_W'(2048);
	localparam int PCM_MAX = 32767;
	localparam int PCM_MIN = -32768;

	// Command codes carried by the cmd field.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_MIX  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IN_CNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_CNT = 1'b1;

	// Mix sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_EMIT
	} dmx_state_t;

endpackage

// ===== sv/pcm_channel_downmix_mixer_core.sv =====
// A gain load item leaves the sequencer idle, ready for the next item. A mix item works through
// the output channels in turn, using the single shared multiply-accumulate that handles one gain
// word per cycle, plus a three-stage read, multiply and accumulate drain per output channel.
// Throughput: one item at a time; in_stall is high from the accept of a mix item until its
// last result has gone into the output register. A stalled output adds its wait time.
// Reset: arst_n clears the sequencer, the output valid, the gain valid bits (so every gain
// reads as zero) and sets both channel counts to two.
// Top level of the PCM channel downmix mixer: gain table, sequencer and shared MAC.
// Depends on dmx_pkg.
module pcm_channel_downmix_mixer_core #(
	parameter int unsigned MAX_IN_CHANNELS  = dmx_pkg::MAX_IN_DEF,
	parameter int unsigned MAX_OUT_CHANNELS = dmx_pkg::MAX_OUT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port
	input  logic                                  cfg_we,
	input  logic [dmx_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dmx_pkg::CFG_W-1:0]             cfg_wdata,
	// Input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  cmd,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0]   sample_0,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0]   sample_1,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0]   sample_2,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0]   sample_3,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0]   sample_4,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0]   sample_5,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0]   sample_6,
	input  logic signed [dmx_pkg::SAMPLE_W-1:0]   sample_7,
	input  logic [dmx_pkg::IDX_W-1:0]             gain_out_index,
	input  logic [dmx_pkg::IDX_W-1:0]             gain_in_index,
	input  logic [dmx_pkg::GAIN_W-1:0]            gain_value,
	// Output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [dmx_pkg::IDX_W-1:0]             out_channel,
	output logic signed [dmx_pkg::SAMPLE_W-1:0]   out_sample,
	output logic                                  last
);
	import dmx_pkg::*;

	localparam logic [CNT_W-1:0] MAX_IN_CNT  = CNT_W'(MAX_IN_CHANNELS);
	localparam logic [CNT_W-1:0] MAX_OUT_CNT = CNT_W'(MAX_OUT_CHANNELS);
	localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'(PCM_MAX);
	localparam logic signed [RND_W-1:0] SAT_MIN = RND_W'(PCM_MIN);

	// Configuration registers and gain table storage.
	logic [CFG_W-1:0]          in_cnt_q, out_cnt_q;
	logic [GAIN_W-1:0]         gain_mem [TBL_DEPTH];
	logic [TBL_DEPTH-1:0]      gain_vld_q;

	// Sequencer state and per-frame registers.
	dmx_state_t                state_q, state_d;
	logic signed [SAMPLE_W-1:0] samp_q [TBL_SIDE];
	logic [CNT_W-1:0]          n_in_q, n_out_q;
	logic [IDX_W-1:0]          in_idx_q, out_idx_q;
	logic signed [ACC_W-1:0]   acc_q;

	// MAC pipeline registers.
	logic                      rd_v_s1, mul_v_s2;
	logic [IDX_W-1:0]          idx_s1;
	logic [GAIN_W-1:0]         gain_s1;
	logic                      gvld_s1;
	logic signed [PROD_W-1:0]  prod_s2;

	// Output register.
	logic                      out_valid_q;
	logic [IDX_W-1:0]          out_channel_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                      last_q;

	// Control decodes.
	logic                      in_fire, load_fire, mix_fire, load_ok;
	logic                      issue_en, emit_fire, out_free;
	logic                      last_term, last_chan;
	logic [CNT_W-1:0]          n_in_clamp, n_out_clamp;
	logic [TBL_ADDR_W-1:0]     rd_addr, wr_addr;
	logic [GAIN_W-1:0]         gain_eff;
	logic signed [ACC_W-1:0]   acc_rnd;
	logic signed [RND_W-1:0]   q_rnd;
	logic signed [SAMPLE_W-1:0] sat_val;

	assign in_fire   = in_valid && !in_stall;
	assign load_fire = in_fire && (cmd == CMD_LOAD);
	assign mix_fire  = in_fire && (cmd == CMD_MIX);
	assign load_ok   = ({1'b0, gain_out_index} < MAX_OUT_CNT) &&
	                   ({1'b0, gain_in_index} < MAX_IN_CNT);
	assign wr_addr   = {gain_out_index, gain_in_index};
	assign rd_addr   = {out_idx_q, in_idx_q};
	assign out_free  = !out_valid_q || !out_stall;

	// Channel counts above the built limits saturate to the limits.
	assign n_in_clamp  = (in_cnt_q > MAX_IN_CNT) ? MAX_IN_CNT : in_cnt_q;
	assign n_out_clamp = (out_cnt_q > MAX_OUT_CNT) ? MAX_OUT_CNT : out_cnt_q;

	assign last_term = ({1'b0, in_idx_q} == (n_in_q - CNT_W'(1)));
	assign last_chan = ({1'b0, out_idx_q} == (n_out_q - CNT_W'(1)));

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= IN_CNT_RST;
			out_cnt_q <= OUT_CNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_CNT:  in_cnt_q  <= cfg_wdata;
				REG_OUT_CNT: out_cnt_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Gain table: one write port for load items, one registered read port for the MAC.
	always_ff @(posedge clk) begin
		if (load_fire && load_ok) begin
			gain_mem[wr_addr] <= gain_value;
		end
		gain_s1 <= gain_mem[rd_addr];
	end

	// Valid bits make every entry that was never loaded read as zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_vld_q <= '0;
			gvld_s1    <= 1'b0;
		end else begin
			if (load_fire && load_ok) begin
				gain_vld_q[wr_addr] <= 1'b1;
			end
			gvld_s1 <= gain_vld_q[rd_addr];
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: issue one gain word per cycle, drain the MAC, then emit the channel.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (mix_fire && (n_out_clamp != '0)) begin
					state_d = (n_in_clamp == '0) ? ST_WAIT : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (last_term) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!rd_v_s1 && !mul_v_s2) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					if (last_chan) begin
						state_d = ST_IDLE;
					end else begin
						state_d = (n_in_q == '0) ? ST_WAIT : ST_ISSUE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall  = 1'b1;
		issue_en  = 1'b0;
		emit_fire = 1'b0;
		case (state_q)
			ST_IDLE:  in_stall  = 1'b0;
			ST_ISSUE: issue_en  = 1'b1;
			ST_WAIT:  ;
			ST_EMIT:  emit_fire = out_free;
			default:  ;
		endcase
	end

	// Frame capture and channel counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_in_q    <= '0;
			n_out_q   <= '0;
			in_idx_q  <= '0;
			out_idx_q <= '0;
		end else if (mix_fire) begin
			n_in_q    <= n_in_clamp;
			n_out_q   <= n_out_clamp;
			in_idx_q  <= '0;
			out_idx_q <= '0;
		end else if (issue_en) begin
			in_idx_q <= in_idx_q + IDX_W'(1);
		end else if (emit_fire) begin
			in_idx_q  <= '0;
			out_idx_q <= out_idx_q + IDX_W'(1);
		end
	end

	// Sample registers hold the frame for the whole mix.
	always_ff @(posedge clk) begin
		if (mix_fire) begin
			samp_q[0] <= sample_0;
			samp_q[1] <= sample_1;
			samp_q[2] <= sample_2;
			samp_q[3] <= sample_3;
			samp_q[4] <= sample_4;
			samp_q[5] <= sample_5;
			samp_q[6] <= sample_6;
			samp_q[7] <= sample_7;
		end
	end

	// MAC pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1  <= 1'b0;
			mul_v_s2 <= 1'b0;
		end else begin
			rd_v_s1  <= issue_en;
			mul_v_s2 <= rd_v_s1;
		end
	end

	assign gain_eff = gvld_s1 ? gain_s1 : '0;

	// Shared multiplier, then the accumulator that is cleared after each channel.
	always_ff @(posedge clk) begin
		idx_s1  <= in_idx_q;
		prod_s2 <= samp_q[idx_s1] * $signed({1'b0, gain_eff});
		if (mix_fire || emit_fire) begin
			acc_q <= '0;
		end else if (mul_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round half up to an integer, then saturate to the 16-bit range.
	assign acc_rnd = acc_q + GAIN_HALF;
	assign q_rnd   = acc_rnd[ACC_W-1:GAIN_FRAC];
	always_comb begin
		if (q_rnd > SAT_MAX) begin
			sat_val = SAMPLE_W'(PCM_MAX);
		end else if (q_rnd < SAT_MIN) begin
			sat_val = SAMPLE_W'(PCM_MIN);
		end else begin
			sat_val = q_rnd[SAMPLE_W-1:0];
		end
	end

	// Output register parts the sequencer from the downstream stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_channel_q <= out_idx_q;
			out_sample_q  <= sat_val;
			last_q        <= last_chan;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign out_sample  = out_sample_q;
	assign last        = last_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pcm_channel_downmix_mixer_core: directed and random items.
// Predicts every mixed output from its own gain map and channel counts; depends on dmx_pkg.
module tb_top;
	import dmx_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 128;
	localparam int MAX_REPORTS  = 10;

	// One input item as it crosses the input handshake.
	typedef struct packed {
		logic                          cmd;
		logic [7:0][SAMPLE_W-1:0]      samples;
		logic [IDX_W-1:0]              gain_out;
		logic [IDX_W-1:0]              gain_in;
		logic [GAIN_W-1:0]             gain;
	} mixer_item_t;

	// One mixed output sample.
	typedef struct packed {
		logic [IDX_W-1:0]              chan;
		logic signed [SAMPLE_W-1:0]    sample;
		logic                          last;
	} mix_out_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index = REG_IN_CNT;
	logic [CFG_W-1:0]              cfg_wdata = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          cmd = CMD_LOAD;
	logic signed [SAMPLE_W-1:0]    sample_0 = '0;
	logic signed [SAMPLE_W-1:0]    sample_1 = '0;
	logic signed [SAMPLE_W-1:0]    sample_2 = '0;
	logic signed [SAMPLE_W-1:0]    sample_3 = '0;
	logic signed [SAMPLE_W-1:0]    sample_4 = '0;
	logic signed [SAMPLE_W-1:0]    sample_5 = '0;
	logic signed [SAMPLE_W-1:0]    sample_6 = '0;
	logic signed [SAMPLE_W-1:0]    sample_7 = '0;
	logic [IDX_W-1:0]              gain_out_index = '0;
	logic [IDX_W-1:0]              gain_in_index = '0;
	logic [GAIN_W-1:0]             gain_value = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [IDX_W-1:0]              out_channel;
	logic signed [SAMPLE_W-1:0]    out_sample;
	logic                          last;

	// Predictor state: gain map and channel counts as the block should hold them.
	logic [GAIN_W-1:0]             gain_map [TBL_DEPTH] = '{default: '0};
	logic [CNT_W-1:0]              in_cnt_model = IN_CNT_RST;
	logic [CNT_W-1:0]              out_cnt_model = OUT_CNT_RST;
	mix_out_t                      pending_mix_out [$];

	int                            err_count = 0;
	int                            cycle_count = 0;
	int                            send_idle_pct = 0;
	int                            recv_stall_pct = 0;

	pcm_channel_downmix_mixer_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.sample_0       (sample_0),
		.sample_1       (sample_1),
		.sample_2       (sample_2),
		.sample_3       (sample_3),
		.sample_4       (sample_4),
		.sample_5       (sample_5),
		.sample_6       (sample_6),
		.sample_7       (sample_7),
		.gain_out_index (gain_out_index),
		.gain_in_index  (gain_in_index),
		.gain_value     (gain_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_channel    (out_channel),
		.out_sample     (out_sample),
		.last           (last)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run-away guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("pcm_channel_downmix_mixer_core test failed");
			$finish;
		end
	end

	// Random back-pressure on the output side.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Compare each accepted output with the oldest predicted one.
	always @(posedge clk) begin
		mix_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_mix_out.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("unexpected output: chan %0d sample %0d last %0b",
						out_channel, out_sample, last);
			end else begin
				want = pending_mix_out.pop_front();
				if (out_channel !== want.chan || out_sample !== want.sample
						|| last !== want.last) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("mismatch: expected chan %0d sample %0d last %0b, got chan %0d sample %0d last %0b",
							want.chan, want.sample, want.last,
							out_channel, out_sample, last);
				end
			end
		end
	end

	// Update the gain map on a load, or work out every output of a mixed frame.
	task automatic apply_item(input mixer_item_t it);
		int       n_in;
		int       n_out;
		longint   acc;
		longint   rounded;
		mix_out_t r;
		if (it.cmd == CMD_LOAD) begin
			gain_map[{it.gain_out, it.gain_in}] = it.gain;
			return;
		end
		n_in = (in_cnt_model > MAX_IN_DEF) ? MAX_IN_DEF : in_cnt_model;
		n_out = (out_cnt_model > MAX_OUT_DEF) ? MAX_OUT_DEF : out_cnt_model;
		for (int o = 0; o < n_out; o++) begin
			acc = 0;
			for (int i = 0; i < n_in; i++)
				acc += longint'($signed(it.samples[i])) *
					longint'(gain_map[o * TBL_SIDE + i]);
			// Round half up, then clamp to the sample range.
			rounded = (acc + 2048) >>> GAIN_FRAC;
			if (rounded > PCM_MAX)
				rounded = PCM_MAX;
			else if (rounded < PCM_MIN)
				rounded = PCM_MIN;
			r.chan = IDX_W'(o);
			r.sample = SAMPLE_W'(rounded);
			r.last = (o == n_out - 1);
			pending_mix_out.insert(pending_mix_out.size(), r);
		end
	endtask

	// Present one item, with optional idle cycles first, and wait for its accept.
	task automatic send_item(input mixer_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cmd <= it.cmd;
		sample_0 <= it.samples[0];
		sample_1 <= it.samples[1];
		sample_2 <= it.samples[2];
		sample_3 <= it.samples[3];
		sample_4 <= it.samples[4];
		sample_5 <= it.samples[5];
		sample_6 <= it.samples[6];
		sample_7 <= it.samples[7];
		gain_out_index <= it.gain_out;
		gain_in_index <= it.gain_in;
		gain_value <= it.gain;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		apply_item(it);
	endtask

	// Let all outputs arrive and the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_mix_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both channel count registers while the block is idle.
	task automatic set_counts(input logic [CNT_W-1:0] n_in, input logic [CNT_W-1:0] n_out);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_IN_CNT;
		cfg_wdata <= n_in;
		@(posedge clk);
		in_cnt_model = n_in;
		cfg_index <= REG_OUT_CNT;
		cfg_wdata <= n_out;
		@(posedge clk);
		out_cnt_model = n_out;
		cfg_we <= 1'b0;
	endtask

	// Samples biased toward the extremes and small values.
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return '0;
			3: return SAMPLE_W'($urandom_range(512) - 256);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Gains biased toward zero, unity, full scale and modest values.
	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(9))
			0: return '0;
			1: return GAIN_W'(4096);
			2: return 16'hFFFF;
			3, 4, 5: return GAIN_W'($urandom_range(8191));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// Channel counts including zero and values above the channel limit.
	function automatic logic [CNT_W-1:0] rand_count();
		case ($urandom_range(9))
			0: return '0;
			1: return CNT_W'($urandom_range(15, 9));
			2: return CNT_W'(8);
			3: return CNT_W'(1);
			default: return CNT_W'($urandom_range(8, 1));
		endcase
	endfunction

	function automatic mixer_item_t mix_item();
		mixer_item_t it;
		it.cmd = CMD_MIX;
		for (int i = 0; i < 8; i++)
			it.samples[i] = rand_sample();
		it.gain_out = IDX_W'($urandom);
		it.gain_in = IDX_W'($urandom);
		it.gain = GAIN_W'($urandom);
		return it;
	endfunction

	function automatic mixer_item_t load_item(int o, int i, logic [GAIN_W-1:0] g);
		mixer_item_t it;
		it = mix_item();
		it.cmd = CMD_LOAD;
		it.gain_out = IDX_W'(o);
		it.gain_in = IDX_W'(i);
		it.gain = g;
		return it;
	endfunction

	// With the map cleared by reset every output is zero.
	task automatic test_cleared_map();
		mixer_item_t it;
		it = mix_item();
		it.samples[0] = 16'h7FFF;
		it.samples[1] = 16'h8000;
		send_item(it);
	endtask

	// A gain of exactly one passes the input through unchanged.
	task automatic test_unity_passthrough();
		mixer_item_t it;
		send_item(load_item(0, 0, GAIN_W'(4096)));
		send_item(load_item(1, 1, GAIN_W'(4096)));
		it = mix_item();
		it.samples[0] = 16'h8000;
		it.samples[1] = 16'h7FFF;
		send_item(it);
		it.samples[0] = 16'h7FFF;
		it.samples[1] = 16'h8000;
		send_item(it);
	endtask

	// A full-scale gain drives the sum past both ends of the sample range.
	task automatic test_saturation();
		mixer_item_t it;
		send_item(load_item(0, 1, 16'hFFFF));
		it = mix_item();
		it.samples[0] = 16'h7FFF;
		it.samples[1] = 16'h7FFF;
		send_item(it);
		it.samples[0] = 16'h8000;
		it.samples[1] = 16'h8000;
		send_item(it);
	endtask

	// A gain of one half puts odd samples exactly on the rounding boundary.
	task automatic test_rounding();
		mixer_item_t it;
		send_item(load_item(1, 0, GAIN_W'(2048)));
		it = mix_item();
		it.samples[1] = '0;
		it.samples[0] = SAMPLE_W'(1);
		send_item(it);
		it.samples[0] = SAMPLE_W'(-1);
		send_item(it);
		it.samples[0] = SAMPLE_W'(-3);
		send_item(it);
	endtask

	// Full, empty and over-range channel counts.
	task automatic test_channel_counts();
		set_counts(CNT_W'(8), CNT_W'(8));
		send_item(load_item(7, 7, 16'hFFFF));
		send_item(load_item(7, 0, GAIN_W'(1)));
		send_item(mix_item());
		set_counts('0, CNT_W'(8));
		send_item(mix_item());
		set_counts(CNT_W'(8), '0);
		send_item(mix_item());
		set_counts(CNT_W'(15), CNT_W'(15));
		send_item(mix_item());
	endtask

	// Random loads and frames in blocks, each block with fresh channel counts.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
		int sent;
		int block_len;
		sent = 0;
		while (sent < n_items) begin
			set_counts(rand_count(), rand_count());
			send_idle_pct = idle_pct;
			recv_stall_pct = stall_pct;
			block_len = $urandom_range(30, 10);
			for (int k = 0; k < block_len && sent < n_items; k++) begin
				if ($urandom_range(99) < 30)
					send_item(load_item($urandom_range(7), $urandom_range(7), rand_gain()));
				else
					send_item(mix_item());
				sent++;
			end
		end
	endtask

	// Reset once, then run every test in turn.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cleared_map();
		test_unity_passthrough();
		test_saturation();
		test_rounding();
		test_channel_counts();
		test_random_traffic(0, 0, 120);
		test_random_traffic(48, 0, 120);
		test_random_traffic(0, 48, 120);
		test_random_traffic(13, 13, 120);
		wait_idle();
		if (err_count == 0) begin
			$display("pcm_channel_downmix_mixer_core test passed");
		end else begin
			$display("pcm_channel_downmix_mixer_core test failed");
		end
		$finish;
	end

endmodule
